>>> design/vrtr_pkg.sv
// shared types, constants and wrap helpers for the variable record trace ring
// used by every module of the block but vrtr_ram; no dependencies
`default_nettype none

package vrtr_pkg;

    localparam int BUFFER_BYTES = 1024;
    localparam int MAX_RECORDS  = 16;

    localparam int PTR_W  = $clog2(BUFFER_BYTES);
    localparam int SLOT_W = $clog2(MAX_RECORDS);
    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
    localparam int LEN_W  = PTR_W;
    localparam int FREE_W = $clog2(BUFFER_BYTES + 1);

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef struct packed {
        logic        op;
        logic [7:0]  data_byte;
        logic        first_byte;
        logic [10:0] record_len;
        logic [3:0]  entry_index;
        logic [9:0]  byte_index;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [9:0] read_record_len;
        logic       read_hit;
        logic       write_accepted;
        logic       record_committed;
        logic [4:0] stored_records;
        logic       buffer_empty;
    } out_item_t;

    typedef struct packed {
        logic [PTR_W-1:0] offset;
        logic [LEN_W-1:0] len;
    } tab_entry_t;

    localparam int TAB_W = $bits(tab_entry_t);

    typedef struct packed {
        logic             we;
        logic [PTR_W-1:0] waddr;
        logic [7:0]       wdata;
        logic             re;
        logic [PTR_W-1:0] raddr;
    } byte_req_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        tab_entry_t        wdata;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } tab_req_t;

    // circular byte address add, both operands below the buffer size
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] a,
                                                 input logic [PTR_W-1:0] b);
        logic [PTR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (PTR_W+1)'(BUFFER_BYTES))
            s = s - (PTR_W+1)'(BUFFER_BYTES);
        return s[PTR_W-1:0];
    endfunction

    // circular slot add, both operands below the slot count
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                   input logic [SLOT_W-1:0] b);
        logic [SLOT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (SLOT_W+1)'(MAX_RECORDS))
            s = s - (SLOT_W+1)'(MAX_RECORDS);
        return s[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> design/vrtr_ram.sv
// generic single write port, single read port ram with registered read data
// no package dependency
`default_nettype none

module vrtr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // read data holds until the next read
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/vrtr_out.sv
// result output register with one skid entry behind it
// depends on vrtr_pkg for the result item type
`default_nettype none

module vrtr_out (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire vrtr_pkg::out_item_t res,
    output logic                    skid_full,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output vrtr_pkg::out_item_t     rsp_item
);
    import vrtr_pkg::*;

    logic      main_valid_reg, main_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t main_reg, main_next;
    out_item_t skid_reg, skid_next;
    logic      pop;

    assign pop = main_valid_reg && !rsp_stall;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_next       = res;
                skid_valid_next = push;
            end
            else
            begin
                main_next       = res;
                main_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign skid_full = skid_valid_reg;
    assign rsp_valid = main_valid_reg;
    assign rsp_item  = main_reg;

    // the skid entry is only ever used behind a held main entry
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry valid without main entry");

    // a stalled output keeps its item
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        main_valid_reg && rsp_stall |=> main_valid_reg && main_reg == $past(main_reg))
        else $error("stalled output item changed");

    // no push may arrive while both entries are full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !(skid_valid_reg && rsp_stall))
        else $error("push into a full output buffer");

endmodule

`default_nettype wire

>>> design/vrtr_ctrl.sv
// item sequencer: eviction, append, commit and read over the byte store and
// record table rams; depends on vrtr_pkg
`default_nettype none

module vrtr_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire vrtr_pkg::in_item_t  req_item,
    input  wire logic                skid_full,
    output logic                     push,
    output vrtr_pkg::out_item_t      res,
    output vrtr_pkg::byte_req_t      byte_req,
    input  wire logic [7:0]          byte_rdata,
    output vrtr_pkg::tab_req_t       tab_req,
    input  wire vrtr_pkg::tab_entry_t tab_rdata
);
    import vrtr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_EXEC    = 5'b00010,
        S_EVICT   = 5'b00100,
        S_RD_TAB  = 5'b01000,
        S_RD_BYTE = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    in_item_t          item_reg, item_next;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [PTR_W-1:0]  oldest_ptr_reg, oldest_ptr_next;
    logic [PTR_W-1:0]  cur_ptr_reg, cur_ptr_next;
    logic [PTR_W-1:0]  open_start_reg, open_start_next;
    logic [SLOT_W-1:0] wslot_reg, wslot_next;
    logic [SLOT_W-1:0] oslot_reg, oslot_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;

    logic              accept;
    logic              len_ok;
    logic [LEN_W-1:0]  len_q;
    logic [FREE_W-1:0] free_bytes;
    logic [FREE_W-1:0] len_plus1;
    logic              need_evict;
    logic [PTR_W-1:0]  ptr_inc;

    assign req_stall = (state_reg != S_IDLE) || skid_full;
    assign accept    = req_valid && !req_stall;

    assign len_ok = (item_reg.record_len != '0)
                 && (32'(item_reg.record_len) <= BUFFER_BYTES - 2);
    assign len_q     = item_reg.record_len[LEN_W-1:0];
    assign len_plus1 = FREE_W'(len_q) + FREE_W'(1);

    always_comb
    begin
        if (count_reg == '0)
            free_bytes = FREE_W'(BUFFER_BYTES);
        else if (wp_reg >= oldest_ptr_reg)
            free_bytes = FREE_W'(BUFFER_BYTES) - FREE_W'(wp_reg) + FREE_W'(oldest_ptr_reg);
        else
            free_bytes = FREE_W'(oldest_ptr_reg) - FREE_W'(wp_reg);
    end

    assign need_evict = (count_reg >= CNT_W'(MAX_RECORDS)) || (free_bytes <= len_plus1);

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        wp_next         = wp_reg;
        oldest_ptr_next = oldest_ptr_reg;
        cur_ptr_next    = cur_ptr_reg;
        open_start_next = open_start_reg;
        wslot_next      = wslot_reg;
        oslot_next      = oslot_reg;
        count_next      = count_reg;
        rem_next        = rem_reg;
        byte_req        = '0;
        tab_req         = '0;
        push            = 1'b0;
        res             = '0;
        ptr_inc         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next  = req_item;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (item_reg.op == OP_READ)
                begin
                    if (CNT_W'(item_reg.entry_index) < count_reg)
                    begin
                        tab_req.re    = 1'b1;
                        tab_req.raddr = slot_add(oslot_reg,
                                                 item_reg.entry_index[SLOT_W-1:0]);
                        state_next    = S_RD_TAB;
                    end
                    else
                    begin
                        push       = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (item_reg.first_byte)
                begin
                    // a new first byte drops whatever record was open
                    rem_next = '0;
                    if (!len_ok)
                    begin
                        push       = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (need_evict)
                    begin
                        tab_req.re    = 1'b1;
                        tab_req.raddr = slot_add(oslot_reg, SLOT_W'(1));
                        oslot_next    = slot_add(oslot_reg, SLOT_W'(1));
                        count_next    = count_reg - CNT_W'(1);
                        state_next    = S_EVICT;
                    end
                    else
                    begin
                        tab_req.we           = 1'b1;
                        tab_req.waddr        = wslot_reg;
                        tab_req.wdata.offset = wp_reg;
                        tab_req.wdata.len    = len_q;
                        byte_req.we          = 1'b1;
                        byte_req.waddr       = wp_reg;
                        byte_req.wdata       = item_reg.data_byte;
                        ptr_inc              = ptr_add(wp_reg, PTR_W'(1));
                        open_start_next      = wp_reg;
                        cur_ptr_next         = ptr_inc;
                        rem_next             = len_q - LEN_W'(1);
                        res.write_accepted   = 1'b1;
                        if (len_q == LEN_W'(1))
                        begin
                            res.record_committed = 1'b1;
                            wp_next              = ptr_inc;
                            wslot_next           = slot_add(wslot_reg, SLOT_W'(1));
                            count_next           = count_reg + CNT_W'(1);
                            if (count_reg == '0)
                                oldest_ptr_next = wp_reg;
                        end
                        push       = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    if (rem_reg != '0)
                    begin
                        byte_req.we        = 1'b1;
                        byte_req.waddr     = cur_ptr_reg;
                        byte_req.wdata     = item_reg.data_byte;
                        ptr_inc            = ptr_add(cur_ptr_reg, PTR_W'(1));
                        cur_ptr_next       = ptr_inc;
                        rem_next           = rem_reg - LEN_W'(1);
                        res.write_accepted = 1'b1;
                        if (rem_reg == LEN_W'(1))
                        begin
                            res.record_committed = 1'b1;
                            wp_next              = ptr_inc;
                            wslot_next           = slot_add(wslot_reg, SLOT_W'(1));
                            count_next           = count_reg + CNT_W'(1);
                            if (count_reg == '0)
                                oldest_ptr_next = open_start_reg;
                        end
                    end
                    push       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_EVICT:
            begin
                // table data is the offset of the new oldest record
                if (count_reg != '0)
                    oldest_ptr_next = tab_rdata.offset;
                else
                    oldest_ptr_next = wp_reg;
                state_next = S_EXEC;
            end

            S_RD_TAB:
            begin
                if (32'(item_reg.byte_index) < 32'(tab_rdata.len))
                begin
                    byte_req.re    = 1'b1;
                    byte_req.raddr = ptr_add(tab_rdata.offset,
                                             item_reg.byte_index[PTR_W-1:0]);
                    state_next     = S_RD_BYTE;
                end
                else
                begin
                    res.read_record_len = tab_rdata.len;
                    push                = 1'b1;
                    state_next          = S_IDLE;
                end
            end

            S_RD_BYTE:
            begin
                res.read_record_len = tab_rdata.len;
                res.read_hit        = 1'b1;
                res.read_data       = byte_rdata;
                push                = 1'b1;
                state_next          = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res.stored_records = count_next;
        res.buffer_empty   = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            wp_reg         <= '0;
            oldest_ptr_reg <= '0;
            cur_ptr_reg    <= '0;
            open_start_reg <= '0;
            wslot_reg      <= '0;
            oslot_reg      <= '0;
            count_reg      <= '0;
            rem_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            oldest_ptr_reg <= oldest_ptr_next;
            cur_ptr_reg    <= cur_ptr_next;
            open_start_reg <= open_start_next;
            wslot_reg      <= wslot_next;
            oslot_reg      <= oslot_next;
            count_reg      <= count_next;
            rem_reg        <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    // an item only starts when the output side can take its result
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_full)
        else $error("result pushed into full output skid");

    // each eviction step removes exactly one record
    a_evict_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EVICT |-> count_reg + CNT_W'(1) == $past(count_reg))
        else $error("eviction did not drop one record");

    // the open record's table slot is never a committed one
    a_tab_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        tab_req.we |-> count_reg < CNT_W'(MAX_RECORDS))
        else $error("table write over a committed record");

    // count never leaves its range
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RECORDS))
        else $error("record count out of range");

    // an accepted item is executed on the next cycle
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_EXEC)
        else $error("accepted item not executed");

endmodule

`default_nettype wire

>>> design/variable_record_trace_ring.sv
// variable record trace ring: top level joining sequencer, rams and output stage
// depends on vrtr_pkg, vrtr_ram, vrtr_ctrl and vrtr_out
//
// usage:
//   req channel (req_valid, req_stall, req_item) carries one append or read item;
//   rsp channel (rsp_valid, rsp_stall, rsp_item) returns exactly one result per item,
//   in order. an item moves when valid is high and stall is low at a rising edge.
//   one item is worked at a time by a sequencer around two rams with one write and
//   one read port and registered read data: a 1024 byte circular byte store and
//   a 16 entry record table (offset and length).
//   an append byte or a rejected/absent case ends in the execute step; a read of
//   an existing record whose length is exceeded adds a table read, and a read hit
//   adds a table read and a byte read; a first byte adds an eviction step per
//   evicted record (one table read and pointer update each).
//   a new item is taken only once the previous item has pushed its result.
//   the next item is taken while an earlier result still waits on a stalled rsp;
//   a second waiting result stops intake (req_stall high) until rsp drains.
//   reset clears pointers, record count and the open record; ram contents are
//   left undefined, no clearing pass runs, so items are taken right after reset.
`default_nettype none

module variable_record_trace_ring (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire vrtr_pkg::in_item_t req_item,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output vrtr_pkg::out_item_t     rsp_item
);
    import vrtr_pkg::*;

    byte_req_t        byte_req;
    tab_req_t         tab_req;
    logic [7:0]       byte_rdata;
    logic [TAB_W-1:0] tab_rdata_raw;
    tab_entry_t       tab_rdata;
    logic             push;
    out_item_t        res;
    logic             skid_full;

    assign tab_rdata = tab_entry_t'(tab_rdata_raw);

    vrtr_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_byte_store (
        .clk   (clk),
        .we    (byte_req.we),
        .waddr (byte_req.waddr),
        .wdata (byte_req.wdata),
        .re    (byte_req.re),
        .raddr (byte_req.raddr),
        .rdata (byte_rdata)
    );

    vrtr_ram #(
        .WIDTH (TAB_W),
        .DEPTH (MAX_RECORDS)
    ) u_record_table (
        .clk   (clk),
        .we    (tab_req.we),
        .waddr (tab_req.waddr),
        .wdata (tab_req.wdata),
        .re    (tab_req.re),
        .raddr (tab_req.raddr),
        .rdata (tab_rdata_raw)
    );

    vrtr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_item   (req_item),
        .skid_full  (skid_full),
        .push       (push),
        .res        (res),
        .byte_req   (byte_req),
        .byte_rdata (byte_rdata),
        .tab_req    (tab_req),
        .tab_rdata  (tab_rdata)
    );

    vrtr_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .res       (res),
        .skid_full (skid_full),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

endmodule

`default_nettype wire
